// File: rtl/core/framed_packet_checker_defines.svh
// Assertion macros used by the framed packet checker assertion module (fpc_checker)
`ifndef FRAMED_PACKET_CHECKER_DEFINES_SVH
`define FRAMED_PACKET_CHECKER_DEFINES_SVH

// Concurrent assertion on a named clock and reset
`define FPC_ASSERT_CR(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define FPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: rtl/core/fpc_pkg.sv
// Types, constants and helpers of the framed packet checker
`timescale 1ns / 1ps

package fpc_pkg;

   // Frame phase, one-hot
   typedef enum logic [6:0] {
      PH_START    = 7'b0000001,
      PH_CONTROL  = 7'b0000010,
      PH_LENGTH   = 7'b0000100,
      PH_DATA     = 7'b0001000,
      PH_CHECKSUM = 7'b0010000,
      PH_STOP     = 7'b0100000,
      PH_ERROR    = 7'b1000000
   } fpc_phase_type;

   // Phase codes as reported on the result
   localparam logic [2:0] PHC_START    = 3'd0;
   localparam logic [2:0] PHC_CONTROL  = 3'd1;
   localparam logic [2:0] PHC_LENGTH   = 3'd2;
   localparam logic [2:0] PHC_DATA     = 3'd3;
   localparam logic [2:0] PHC_CHECKSUM = 3'd4;
   localparam logic [2:0] PHC_STOP     = 3'd5;
   localparam logic [2:0] PHC_ERROR    = 3'd6;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_START    = 3'd1,
      ERR_CONTROL  = 3'd2,
      ERR_LENGTH   = 3'd3,
      ERR_CHECKSUM = 3'd4,
      ERR_STOP     = 3'd5
   } fpc_err_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned NUM_CTRL    = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_CODE     = 3'd0,
      REG_STOP_CODE      = 3'd1,
      REG_VALID_CONTROLS = 3'd2,
      REG_MAX_DATA_LEN   = 3'd3
   } fpc_reg_type;

   localparam logic [7:0]  RST_START_CODE     = 8'hAA;
   localparam logic [7:0]  RST_STOP_CODE      = 8'h55;
   localparam logic [63:0] RST_VALID_CONTROLS = 64'h0807_0605_0403_0201;
   localparam logic [7:0]  RST_MAX_DATA_LEN   = 8'd59;
   localparam logic [7:0]  MIN_LEN            = 8'd3;

   typedef struct packed {
      logic [7:0]  start_code;
      logic [7:0]  stop_code;
      logic [63:0] valid_controls;
      logic [7:0]  max_data_len;
   } fpc_cfg_type;

   typedef struct packed {
      fpc_phase_type phase;
      logic [7:0]    running_sum;
      logic [7:0]    bytes_left;
      logic [7:0]    prior_byte;
      logic [7:0]    position;
   } fpc_state_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      logic [7:0]  frame_pos;
      logic        byte_kept;
      logic        frame_done;
      fpc_err_type error_code;
      logic [2:0]  phase_now;
   } fpc_result_type;

   function automatic logic [2:0] phase_code(input fpc_phase_type ph);
      logic [2:0] code;
      begin
         unique case (ph)
            PH_START:    code = PHC_START;
            PH_CONTROL:  code = PHC_CONTROL;
            PH_LENGTH:   code = PHC_LENGTH;
            PH_DATA:     code = PHC_DATA;
            PH_CHECKSUM: code = PHC_CHECKSUM;
            PH_STOP:     code = PHC_STOP;
            default:     code = PHC_ERROR;
         endcase
         return code;
      end
   endfunction

endpackage

// File: rtl/core/fpc_csr.sv
// Configuration registers of the framed packet checker
`timescale 1ns / 1ps

module fpc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [fpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output fpc_pkg::fpc_cfg_type               cfg
);

   fpc_pkg::fpc_cfg_type cfg_ff;
   fpc_pkg::fpc_cfg_type cfg_in;

   // decode the write; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fpc_pkg::REG_START_CODE:     cfg_in.start_code     = csr_wdata[7:0];
            fpc_pkg::REG_STOP_CODE:      cfg_in.stop_code      = csr_wdata[7:0];
            fpc_pkg::REG_VALID_CONTROLS: cfg_in.valid_controls = csr_wdata[63:0];
            fpc_pkg::REG_MAX_DATA_LEN:   cfg_in.max_data_len   = csr_wdata[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code     <= fpc_pkg::RST_START_CODE;
         cfg_ff.stop_code      <= fpc_pkg::RST_STOP_CODE;
         cfg_ff.valid_controls <= fpc_pkg::RST_VALID_CONTROLS;
         cfg_ff.max_data_len   <= fpc_pkg::RST_MAX_DATA_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/fpc_step.sv
// Per-byte frame parsing logic: next state and result from one byte
`timescale 1ns / 1ps

module fpc_step (
   input  fpc_pkg::fpc_cfg_type    cfg,
   input  fpc_pkg::fpc_state_type  cur,
   input  logic [7:0]              rx_byte,
   output fpc_pkg::fpc_state_type  nxt,
   output fpc_pkg::fpc_result_type res
);

   logic                control_ok;
   logic                kept;
   logic                opened;
   logic                done;
   fpc_pkg::fpc_err_type err;
   logic [7:0]          pos_out;
   logic [7:0]          left_dec;

   // match against all eight control slots in parallel
   always_comb begin
      control_ok = 1'b0;
      for (int i = 0; i < fpc_pkg::NUM_CTRL; i++) begin
         if (cfg.valid_controls[8*i +: 8] == rx_byte) begin
            control_ok = 1'b1;
         end
      end
   end

   assign left_dec = cur.bytes_left - 8'd1;

   always_comb begin
      nxt     = cur;
      kept    = 1'b0;
      opened  = 1'b0;
      done    = 1'b0;
      err     = fpc_pkg::ERR_NONE;
      pos_out = 8'd0;
      unique case (cur.phase)
         fpc_pkg::PH_START: begin
            if (rx_byte == cfg.start_code) begin
               nxt.phase = fpc_pkg::PH_CONTROL;
               kept      = 1'b1;
               opened    = 1'b1;
            end else begin
               nxt.phase = fpc_pkg::PH_ERROR;
               err       = fpc_pkg::ERR_START;
            end
         end
         fpc_pkg::PH_CONTROL: begin
            if (control_ok) begin
               nxt.phase       = fpc_pkg::PH_LENGTH;
               nxt.running_sum = rx_byte;
               kept            = 1'b1;
            end else begin
               nxt.phase = fpc_pkg::PH_ERROR;
               err       = fpc_pkg::ERR_CONTROL;
            end
         end
         fpc_pkg::PH_LENGTH: begin
            if (rx_byte >= fpc_pkg::MIN_LEN && rx_byte <= cfg.max_data_len) begin
               nxt.phase       = fpc_pkg::PH_DATA;
               nxt.bytes_left  = rx_byte;
               nxt.running_sum = cur.running_sum + rx_byte;
               kept            = 1'b1;
            end else begin
               nxt.phase = fpc_pkg::PH_ERROR;
               err       = fpc_pkg::ERR_LENGTH;
            end
         end
         fpc_pkg::PH_DATA: begin
            if (cur.bytes_left != 8'd0) begin
               nxt.bytes_left  = left_dec;
               nxt.running_sum = cur.running_sum + rx_byte;
               kept            = 1'b1;
               if (left_dec == 8'd0) begin
                  nxt.phase = fpc_pkg::PH_CHECKSUM;
               end
            end else begin
               nxt.phase = fpc_pkg::PH_CHECKSUM;
            end
         end
         fpc_pkg::PH_CHECKSUM: begin
            if (rx_byte == cur.running_sum) begin
               nxt.phase = fpc_pkg::PH_STOP;
               kept      = 1'b1;
            end else begin
               nxt.phase = fpc_pkg::PH_ERROR;
               err       = fpc_pkg::ERR_CHECKSUM;
            end
         end
         fpc_pkg::PH_STOP: begin
            if (rx_byte == cfg.stop_code) begin
               nxt.phase = fpc_pkg::PH_START;
               kept      = 1'b1;
               done      = 1'b1;
            end else begin
               nxt.phase = fpc_pkg::PH_ERROR;
               err       = fpc_pkg::ERR_STOP;
            end
         end
         default: begin
            // resynchronise on a stop byte followed by a start byte
            if (cur.prior_byte == cfg.stop_code && rx_byte == cfg.start_code) begin
               nxt.phase = fpc_pkg::PH_CONTROL;
               kept      = 1'b1;
               opened    = 1'b1;
            end else begin
               nxt.prior_byte = rx_byte;
            end
         end
      endcase

      if (opened) begin
         nxt.position = 8'd1;
      end else if (kept) begin
         pos_out      = cur.position;
         nxt.position = cur.position + 8'd1;
      end
   end

   always_comb begin
      res.echo_byte  = rx_byte;
      res.frame_pos  = pos_out;
      res.byte_kept  = kept;
      res.frame_done = done;
      res.error_code = err;
      res.phase_now  = fpc_pkg::phase_code(nxt.phase);
   end

endmodule

// File: rtl/core/framed_packet_checker.sv
// Top level of the framed packet checker: byte register, parse step, result register
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  rx_byte, one received byte per request
// rsp_      out        rsp_valid / rsp_ready  echo_byte, frame_pos, byte_kept,
//                                             frame_done, error_code, phase_now
// csr_      in         csr_wr_en              csr_index, csr_wdata (no read-back)
//
// One request a cycle sustained while rsp_ready holds; a result is offered once its
// byte has moved from the byte register (loaded on acceptance) to the result register.
// The frame state advances as a byte moves from the byte register to the result
// register, so stalls on the result side never disturb it.
// A stalled result holds in the result register while one further request waits in
// the byte register; req_ready drops only when both are full.
// Synchronous reset returns the configuration to its defaults and the parser to the
// start phase with all counters, sum and prior byte cleared.

module framed_packet_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_echo_byte,
   output logic [7:0]                      rsp_frame_pos,
   output logic                            rsp_byte_kept,
   output logic                            rsp_frame_done,
   output logic [2:0]                      rsp_error_code,
   output logic [2:0]                      rsp_phase_now,
   input  logic                            csr_wr_en,
   input  logic [fpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fpc_pkg::fpc_cfg_type    cfg;
   fpc_pkg::fpc_state_type  state_ff;
   fpc_pkg::fpc_state_type  state_in;
   fpc_pkg::fpc_result_type res_in;
   fpc_pkg::fpc_result_type res_ff;

   logic       byte_valid_ff;
   logic [7:0] byte_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_take;

   fpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpc_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .rx_byte (byte_ff),
      .nxt     (state_in),
      .res     (res_in)
   );

   // Advance the held byte whenever the result register is free or being emptied
   assign advance   = byte_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Take a new request whenever the byte register is free or moving on
   assign req_ready = !byte_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // Byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_ready) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_rx_byte;
      end
   end

   // Frame state: update only as a byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= fpc_pkg::PH_START;
         state_ff.running_sum <= 8'd0;
         state_ff.bytes_left  <= 8'd0;
         state_ff.prior_byte  <= 8'd0;
         state_ff.position    <= 8'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_echo_byte  = res_ff.echo_byte;
   assign rsp_frame_pos  = res_ff.frame_pos;
   assign rsp_byte_kept  = res_ff.byte_kept;
   assign rsp_frame_done = res_ff.frame_done;
   assign rsp_error_code = res_ff.error_code;
   assign rsp_phase_now  = res_ff.phase_now;

endmodule

// File: rtl/core/fpc_checker.sv
// Port-level assertions for the framed packet checker and their binding
`timescale 1ns / 1ps
`include "framed_packet_checker_defines.svh"

module fpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [7:0]                      req_rx_byte,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_echo_byte,
   input logic [7:0]                      rsp_frame_pos,
   input logic                            rsp_byte_kept,
   input logic                            rsp_frame_done,
   input logic [2:0]                      rsp_error_code,
   input logic [2:0]                      rsp_phase_now,
   input logic                            csr_wr_en,
   input logic [fpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [fpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   `FPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte) && $stable(rsp_frame_pos) && $stable(rsp_phase_now), "stalled result changed")
   `FPC_ASSERT(a_drop_no_pos, rsp_valid && !rsp_byte_kept |-> rsp_frame_pos == 8'd0 && !rsp_frame_done, "dropped byte carries position or done")
   `FPC_ASSERT(a_err_phase, rsp_valid && rsp_error_code != fpc_pkg::ERR_NONE |-> rsp_phase_now == fpc_pkg::PHC_ERROR && !rsp_byte_kept, "error without error phase")
   `FPC_ASSERT_CR(a_done_clean, clock, reset, rsp_valid && rsp_frame_done |-> rsp_phase_now == fpc_pkg::PHC_START && rsp_byte_kept && rsp_error_code == fpc_pkg::ERR_NONE, "frame done in wrong state")

endmodule

bind framed_packet_checker fpc_checker u_fpc_checker (.*);
